[hw/rtl/amat_pkg.sv]
// Shared types, constants and the product-term program for the affine inverse.
`default_nettype none
package amat_pkg;

  // Number of matrix entries and of results per run.
  localparam int unsigned NUM_ENTRIES = 12;
  localparam logic [3:0] LAST_INDEX = 4'd11;
  // Operand index that selects the constant one instead of a stored entry.
  localparam logic [3:0] ONE_INDEX = 4'd12;
  // Number of product terms in the whole program.
  localparam int unsigned NUM_TERMS = 42;

  // One product term: sign * e[a] * e[b] * e[c]; last closes a group.
  typedef struct packed {
    logic [3:0] a;
    logic [3:0] b;
    logic [3:0] c;
    logic       neg;
    logic       last;
  } term_t;

  function automatic term_t mk_term(input int unsigned a, input int unsigned b,
                                    input int unsigned c, input bit neg,
                                    input bit last);
    term_t t;
    t.a    = 4'(a);
    t.b    = 4'(b);
    t.c    = 4'(c);
    t.neg  = neg;
    t.last = last;
    return t;
  endfunction

  // Program: the determinant first, then one group per result in row-major
  // order. Rotation results use one cofactor, translation results the sum of
  // three cofactors times the translation column.
  function automatic term_t term_rom(input logic [5:0] ptr);
    term_t t;
    case (ptr)
      6'd0:  t = mk_term(0, 5, 10, 1'b0, 1'b0);
      6'd1:  t = mk_term(0, 6, 9, 1'b1, 1'b0);
      6'd2:  t = mk_term(1, 6, 8, 1'b0, 1'b0);
      6'd3:  t = mk_term(1, 4, 10, 1'b1, 1'b0);
      6'd4:  t = mk_term(2, 4, 9, 1'b0, 1'b0);
      6'd5:  t = mk_term(2, 5, 8, 1'b1, 1'b1);
      6'd6:  t = mk_term(5, 10, 12, 1'b0, 1'b0);
      6'd7:  t = mk_term(6, 9, 12, 1'b1, 1'b1);
      6'd8:  t = mk_term(2, 9, 12, 1'b0, 1'b0);
      6'd9:  t = mk_term(1, 10, 12, 1'b1, 1'b1);
      6'd10: t = mk_term(1, 6, 12, 1'b0, 1'b0);
      6'd11: t = mk_term(2, 5, 12, 1'b1, 1'b1);
      6'd12: t = mk_term(5, 10, 3, 1'b0, 1'b0);
      6'd13: t = mk_term(6, 9, 3, 1'b1, 1'b0);
      6'd14: t = mk_term(2, 9, 7, 1'b0, 1'b0);
      6'd15: t = mk_term(1, 10, 7, 1'b1, 1'b0);
      6'd16: t = mk_term(1, 6, 11, 1'b0, 1'b0);
      6'd17: t = mk_term(2, 5, 11, 1'b1, 1'b1);
      6'd18: t = mk_term(6, 8, 12, 1'b0, 1'b0);
      6'd19: t = mk_term(4, 10, 12, 1'b1, 1'b1);
      6'd20: t = mk_term(0, 10, 12, 1'b0, 1'b0);
      6'd21: t = mk_term(2, 8, 12, 1'b1, 1'b1);
      6'd22: t = mk_term(2, 4, 12, 1'b0, 1'b0);
      6'd23: t = mk_term(0, 6, 12, 1'b1, 1'b1);
      6'd24: t = mk_term(6, 8, 3, 1'b0, 1'b0);
      6'd25: t = mk_term(4, 10, 3, 1'b1, 1'b0);
      6'd26: t = mk_term(0, 10, 7, 1'b0, 1'b0);
      6'd27: t = mk_term(2, 8, 7, 1'b1, 1'b0);
      6'd28: t = mk_term(2, 4, 11, 1'b0, 1'b0);
      6'd29: t = mk_term(0, 6, 11, 1'b1, 1'b1);
      6'd30: t = mk_term(4, 9, 12, 1'b0, 1'b0);
      6'd31: t = mk_term(5, 8, 12, 1'b1, 1'b1);
      6'd32: t = mk_term(1, 8, 12, 1'b0, 1'b0);
      6'd33: t = mk_term(0, 9, 12, 1'b1, 1'b1);
      6'd34: t = mk_term(0, 5, 12, 1'b0, 1'b0);
      6'd35: t = mk_term(1, 4, 12, 1'b1, 1'b1);
      6'd36: t = mk_term(4, 9, 3, 1'b0, 1'b0);
      6'd37: t = mk_term(5, 8, 3, 1'b1, 1'b0);
      6'd38: t = mk_term(1, 8, 7, 1'b0, 1'b0);
      6'd39: t = mk_term(0, 9, 7, 1'b1, 1'b0);
      6'd40: t = mk_term(0, 5, 11, 1'b0, 1'b0);
      6'd41: t = mk_term(1, 4, 11, 1'b1, 1'b1);
      default: t = mk_term(0, 0, 0, 1'b0, 1'b1);
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/amat_if.sv]
// Valid/ready channel interfaces for matrix entries and inverse results.
`default_nettype none
interface amat_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] entry_value;
  logic [3:0]         entry_index;

  modport source (output valid, output entry_value, output entry_index, input ready);
  modport sink (input valid, input entry_value, input entry_index, output ready);
endinterface

interface amat_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [3:0]         result_index;
  logic               singular;
  logic               last;

  modport source (output valid, output result_value, output result_index,
                  output singular, output last, input ready);
  modport sink (input valid, input result_value, input result_index,
                input singular, input last, output ready);
endinterface
`default_nettype wire

[hw/rtl/amat_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module amat_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 12
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hw/rtl/amat_div.sv]
// Restoring divider producing a truncated, saturated signed quotient.
`default_nettype none
module amat_div #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned NUM_W     = 200
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [NUM_W-1:0]     num,
  input  wire logic [NUM_W-1:0]     den,
  input  wire logic                 neg,
  output      logic                 done,
  output      logic [WORD_BITS-1:0] value
);

  localparam int unsigned CW = $clog2(WORD_BITS + 1);
  localparam logic [WORD_BITS-1:0] MIN_PAT = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [WORD_BITS-1:0] MAX_PAT = ~MIN_PAT;

  logic                 busy;
  logic [CW-1:0]        cnt;
  logic [NUM_W-1:0]     rem;
  logic [NUM_W-1:0]     den_sh;
  logic [WORD_BITS-1:0] q;
  logic                 sat;
  logic                 neg_q;
  logic                 fits;

  assign fits = (rem >= den_sh);

  // One quotient bit per cycle, most significant first.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(WORD_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= num;
      den_sh <= den << (WORD_BITS - 1);
      sat    <= (num >= (den << WORD_BITS));
      neg_q  <= neg;
      q      <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - den_sh;
      end
      q      <= {q[WORD_BITS-2:0], fits};
      den_sh <= den_sh >> 1;
    end
  end

  // Apply the sign and saturate to the signed word range.
  always_comb begin
    if (neg_q) begin
      value = (sat || q > MIN_PAT) ? MIN_PAT : WORD_BITS'(-q);
    end else begin
      value = (sat || q > MAX_PAT) ? MAX_PAT : q;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/affine_matrix_inverse_top.sv]
// Affine 3x4 matrix inverse: entry store, term sequencer and result port.
//
// The entry channel takes one transaction per matrix entry, value in signed
// fixed point and index row*4+column. Indexes 12 to 15 are dropped. Index 11
// stores its entry and starts a run; the entry channel is held off until the
// run has delivered its twelve results on the result channel, in row-major
// order, with last on the twelfth. A zero determinant gives twelve zero
// results with singular set.
// Loading accepts one entry per cycle while the block is idle. A nonsingular
// run evaluates 42 triple products on one shared multiplier, each as a read
// of entries a and b from the store, then three multiplies, and one divide
// per result.
// A stalled receiver holds the current result and the run waits with it.
// Reset returns the block to idle; the entry store keeps no valid state and
// must be loaded before the first run.
`default_nettype none
module affine_matrix_inverse_top #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input wire logic    clk,
  input wire logic    rst,
  amat_in_if.sink     entry,
  amat_out_if.source  result
);

  localparam int unsigned W     = WORD_BITS;
  localparam int unsigned ACC_W = 3 * W + 2;
  localparam int unsigned DIV_W = ACC_W + 2 * FRAC_BITS + W + 3;
  localparam int unsigned AW    = $clog2(amat_pkg::NUM_ENTRIES);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RDAB = 8'b0000_0010,
    S_MULAB = 8'b0000_0100,
    S_MULLO = 8'b0000_1000,
    S_MULHI = 8'b0001_0000,
    S_DIVS = 8'b0010_0000,
    S_DIVW = 8'b0100_0000,
    S_OUT = 8'b1000_0000
  } state_t;

  state_t                   state;
  logic [5:0]               ptr;
  logic [3:0]               k;
  logic                     det_phase;
  logic                     singular;
  logic                     one_c;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_next;
  logic signed [ACC_W-1:0]  det;
  logic [2*W-1:0]           p;
  logic [W-1:0]             c_hold;
  logic [31:0]              value;
  amat_pkg::term_t          term;

  logic                     load;
  logic [W-1:0]             wdata;
  logic [AW-1:0]            addr_a;
  logic [AW-1:0]            addr_b;
  logic [W-1:0]             rdata_a;
  logic [W-1:0]             rdata_b;
  logic [W-1:0]             c_op;
  logic [3:0]               c_idx;

  logic signed [W:0]        mul_a;
  logic signed [W:0]        mul_b;
  logic signed [2*W+1:0]    mul_p;
  logic signed [ACC_W-1:0]  addend;

  logic                     acc_neg;
  logic                     det_neg;
  logic                     j3;
  logic [ACC_W-1:0]         acc_mag;
  logic [ACC_W-1:0]         det_mag;
  logic [DIV_W-1:0]         num_a;
  logic [DIV_W-1:0]         div_num;
  logic [DIV_W-1:0]         div_den;
  logic                     div_neg;
  logic                     div_done;
  logic [W-1:0]             div_value;

  assign term  = amat_pkg::term_rom(ptr);
  assign load  = entry.valid && entry.ready && (entry.entry_index <= amat_pkg::LAST_INDEX);
  assign wdata = W'($unsigned(entry.entry_value));
  assign c_idx = term.c;

  // Store read addresses: operands a and b, then operand c on port A.
  assign addr_a = (state == S_MULAB) ?
                  ((c_idx == amat_pkg::ONE_INDEX) ? '0 : AW'(c_idx)) : AW'(term.a);
  assign addr_b = AW'(term.b);

  // Two copies of the entry store give two reads per cycle.
  amat_ram #(.WIDTH(W), .DEPTH(amat_pkg::NUM_ENTRIES)) u_ram_a (
    .clk   (clk),
    .we    (load),
    .waddr (AW'(entry.entry_index)),
    .wdata (wdata),
    .raddr (addr_a),
    .rdata (rdata_a)
  );

  amat_ram #(.WIDTH(W), .DEPTH(amat_pkg::NUM_ENTRIES)) u_ram_b (
    .clk   (clk),
    .we    (load),
    .waddr (AW'(entry.entry_index)),
    .wdata (wdata),
    .raddr (addr_b),
    .rdata (rdata_b)
  );

  assign c_op = one_c ? W'(1) : rdata_a;

  // Shared multiplier: a*b, then the low and high halves of that times c.
  always_comb begin
    case (state)
      S_MULAB: begin
        mul_a = {rdata_a[W-1], rdata_a};
        mul_b = {rdata_b[W-1], rdata_b};
      end
      S_MULLO: begin
        mul_a = {1'b0, p[W-1:0]};
        mul_b = {c_op[W-1], c_op};
      end
      default: begin
        mul_a = {p[2*W-1], p[2*W-1:W]};
        mul_b = {c_hold[W-1], c_hold};
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Accumulate the signed partial product.
  always_comb begin
    addend = ACC_W'(mul_p);
    if (state == S_MULHI) begin
      addend = addend <<< W;
    end
    acc_next = term.neg ? (acc - addend) : (acc + addend);
  end

  // Divider operands: |num| * 2 + |det| over 2 * |det| rounds half away.
  always_comb begin
    acc_neg = acc[ACC_W-1];
    det_neg = det[ACC_W-1];
    j3      = (k[1:0] == 2'd3);
    acc_mag = acc_neg ? ACC_W'(-acc) : ACC_W'(acc);
    det_mag = det_neg ? ACC_W'(-det) : ACC_W'(det);
    num_a   = j3 ? (DIV_W'(acc_mag) << FRAC_BITS) : (DIV_W'(acc_mag) << (2 * FRAC_BITS));
    div_num = (num_a << 1) + DIV_W'(det_mag);
    div_den = DIV_W'(det_mag) << 1;
    div_neg = (j3 ? (!acc_neg && (acc != '0)) : acc_neg) ^ det_neg;
  end

  amat_div #(.WORD_BITS(W), .NUM_W(DIV_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_DIVS),
    .num   (div_num),
    .den   (div_den),
    .neg   (div_neg),
    .done  (div_done),
    .value (div_value)
  );

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ptr       <= '0;
      k         <= '0;
      det_phase <= 1'b0;
      singular  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (load && entry.entry_index == amat_pkg::LAST_INDEX) begin
            state     <= S_RDAB;
            ptr       <= '0;
            k         <= '0;
            det_phase <= 1'b1;
            singular  <= 1'b0;
          end
        end
        S_RDAB: state <= S_MULAB;
        S_MULAB: state <= S_MULLO;
        S_MULLO: state <= S_MULHI;
        S_MULHI: begin
          ptr <= ptr + 1'b1;
          if (!term.last) begin
            state <= S_RDAB;
          end else if (det_phase) begin
            det_phase <= 1'b0;
            if (acc_next == '0) begin
              singular <= 1'b1;
              state    <= S_OUT;
            end else begin
              state <= S_RDAB;
            end
          end else begin
            state <= S_DIVS;
          end
        end
        S_DIVS: state <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (result.ready) begin
            if (k == amat_pkg::LAST_INDEX) begin
              state <= S_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= singular ? S_OUT : S_RDAB;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: acc <= '0;
      S_MULAB: begin
        p     <= mul_p[2*W-1:0];
        one_c <= (c_idx == amat_pkg::ONE_INDEX);
      end
      S_MULLO: begin
        acc    <= acc_next;
        c_hold <= c_op;
      end
      S_MULHI: begin
        if (term.last && det_phase) begin
          det   <= acc_next;
          acc   <= '0;
          value <= '0;
        end else begin
          acc <= acc_next;
        end
      end
      S_DIVW: begin
        if (div_done) begin
          value <= 32'(div_value);
        end
      end
      S_OUT: begin
        if (result.ready) begin
          acc <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign entry.ready         = (state == S_IDLE);
  assign result.valid        = (state == S_OUT);
  assign result.result_value = value;
  assign result.result_index = k;
  assign result.singular     = singular;
  assign result.last         = (k == amat_pkg::LAST_INDEX);

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    entry.ready |-> !result.valid)
    else $error("entry channel open while a result is pending");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.ready && result.last) |=> entry.ready)
    else $error("block did not return to idle after the last result");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.singular) |-> (result.result_value == '0))
    else $error("singular result carries a nonzero value");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIVW))
    else $error("divider finished outside the wait state");
`endif

endmodule
`default_nettype wire
